// File: sv/css_pkg.sv
// Package: scan modes, character codes and shared types for the comment stripper.
`default_nettype none
package css_pkg;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_SPACE  = 3'd1;
   localparam logic [2:0] MODE_SLASH  = 3'd2;
   localparam logic [2:0] MODE_LINE   = 3'd3;
   localparam logic [2:0] MODE_BLOCK  = 3'd4;
   localparam logic [2:0] MODE_HALTED = 3'd5;

   localparam logic [7:0] CH_NUL    = 8'd0;
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_DQUOTE = 8'd34;
   localparam logic [7:0] CH_SQUOTE = 8'd39;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_SLASH  = 8'd47;

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } step_result_type;

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
                 (c >= 8'd97 && c <= 8'd122);
   endfunction

endpackage
`default_nettype wire

// File: sv/css_scan.sv
// Scanner: mode, previous byte and line mark, with the per-item step logic.
`default_nettype none
module css_scan (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic [7:0]               in_char,
   output css_pkg::step_result_type      result
);

   logic [2:0] mode_ff, mode_in;
   logic [7:0] prev_ff, prev_in;
   logic       lht_ff, lht_in;

   always_comb begin
      mode_in      = mode_ff;
      prev_in      = prev_ff;
      lht_in       = lht_ff;
      result.count = 2'd0;
      result.byte0 = in_char;
      result.byte1 = in_char;
      case (mode_ff)
         css_pkg::MODE_HALTED: begin
         end
         css_pkg::MODE_SPACE: begin
            if (in_char == css_pkg::CH_NUL) begin
               mode_in = css_pkg::MODE_HALTED;
            end else begin
               if (css_pkg::is_alnum(in_char) || in_char == css_pkg::CH_DQUOTE ||
                   in_char == css_pkg::CH_SQUOTE) begin
                  result.count = 2'd2;
                  result.byte0 = css_pkg::CH_SPACE;
               end else begin
                  result.count = 2'd1;
               end
               prev_in = in_char;
               mode_in = css_pkg::MODE_NORMAL;
            end
         end
         css_pkg::MODE_SLASH: begin
            if (in_char == css_pkg::CH_NUL) begin
               mode_in = css_pkg::MODE_HALTED;
            end else if (in_char == css_pkg::CH_SLASH) begin
               mode_in = css_pkg::MODE_LINE;
            end else if (in_char == css_pkg::CH_STAR) begin
               prev_in = css_pkg::CH_SPACE;
               mode_in = css_pkg::MODE_BLOCK;
            end else begin
               result.count = 2'd2;
               result.byte0 = css_pkg::CH_SLASH;
               prev_in      = in_char;
               mode_in      = css_pkg::MODE_NORMAL;
            end
         end
         css_pkg::MODE_LINE: begin
            if (in_char == css_pkg::CH_NL) begin
               prev_in = css_pkg::CH_NL;
               mode_in = css_pkg::MODE_NORMAL;
            end
         end
         css_pkg::MODE_BLOCK: begin
            if (in_char == css_pkg::CH_SLASH && prev_ff == css_pkg::CH_STAR) begin
               mode_in = css_pkg::MODE_NORMAL;
            end
            prev_in = in_char;
         end
         default: begin
            mode_in = css_pkg::MODE_NORMAL;
            if (in_char == css_pkg::CH_SPACE) begin
               if (css_pkg::is_alnum(prev_ff)) begin
                  mode_in = css_pkg::MODE_SPACE;
               end else begin
                  prev_in = css_pkg::CH_SPACE;
               end
            end else if (in_char == css_pkg::CH_SLASH) begin
               mode_in = css_pkg::MODE_SLASH;
            end else if (in_char == css_pkg::CH_NL) begin
               if (lht_ff) begin
                  lht_in       = 1'b0;
                  result.count = 2'd1;
               end
               prev_in = in_char;
            end else begin
               lht_in       = 1'b1;
               result.count = 2'd1;
               prev_in      = in_char;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= css_pkg::MODE_NORMAL;
         prev_ff <= css_pkg::CH_SPACE;
         lht_ff  <= 1'b0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
         lht_ff  <= lht_in;
      end
   end

`ifndef ASSERT_OFF
   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == css_pkg::MODE_HALTED |=> mode_ff == css_pkg::MODE_HALTED)
      else $error("halted scanner left halt without reset");
`endif

endmodule
`default_nettype wire

// File: sv/css_obuf.sv
// Result buffer: holds up to two bytes of one item and hands them out in order.
`default_nettype none
module css_obuf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire css_pkg::step_result_type result,
   output logic                          free,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last_of_run
);

   logic       res_v_ff, res_v_in;
   logic       idx_ff, idx_in;
   logic [1:0] count_ff;
   logic [7:0] b0_ff;
   logic [7:0] b1_ff;
   logic       accept;

   assign rsp_valid       = res_v_ff;
   assign rsp_out_char    = idx_ff ? b1_ff : b0_ff;
   assign rsp_last_of_run = idx_ff || (count_ff != 2'd2);
   assign accept          = res_v_ff && !rsp_stall;
   assign free            = !res_v_ff || (accept && rsp_last_of_run);

   always_comb begin
      res_v_in = res_v_ff;
      idx_in   = idx_ff;
      if (load) begin
         res_v_in = 1'b1;
         idx_in   = 1'b0;
      end else if (accept) begin
         if (rsp_last_of_run) begin
            res_v_in = 1'b0;
         end else begin
            idx_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         res_v_ff <= res_v_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= result.count;
         b0_ff    <= result.byte0;
         b1_ff    <= result.byte1;
      end
   end

`ifndef ASSERT_OFF
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result buffer overwritten while holding bytes");
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load |-> result.count != 2'd0)
      else $error("empty result loaded");
   a_second_byte: assert property (@(posedge clock) disable iff (reset)
      res_v_ff && idx_ff |-> count_ff == 2'd2)
      else $error("second byte selected for a single-byte item");
`endif

endmodule
`default_nettype wire

// File: sv/comment_strip_space_squeeze.sv
// Top level: input register, scanner and result buffer of the comment stripper.
//
// Source bytes enter on the req_ channel, one byte per item. Cleaned bytes
// leave on the rsp_ channel; rsp_last_of_run marks the last byte produced
// by one input byte. An input byte gives zero, one or two output bytes.
// A byte accepted into the input register is scanned from there; its output
// bytes are registered in the result buffer and offered from it.
// Throughput: one input byte per cycle while each gives at most one output
// byte and the receiver does not stall; a byte that gives two output bytes
// holds the result buffer until both are taken, as the output port carries one
// byte at a time. Bytes giving no output never wait on the result buffer.
// Reset (synchronous, active high) empties both registers and returns the
// scanner to plain text with no line text and a space as previous byte.
// A zero byte after a pending space or slash halts the stream: later bytes
// are accepted and dropped until reset.
// When the receiver stalls, the result buffer holds its byte; the input
// register waits only if its byte produces output, and req_stall rises then.
`default_nettype none
module comment_strip_space_squeeze (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_of_run
);

   logic                     in_v_ff;
   logic [7:0]               in_char_ff;
   logic                     buf_free;
   logic                     advance;
   css_pkg::step_result_type result;

   assign advance   = in_v_ff && (result.count == 2'd0 || buf_free);
   assign req_stall = in_v_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (!req_stall) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_in_char;
      end
   end

   css_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .in_char (in_char_ff),
      .result  (result)
   );

   css_obuf u_obuf (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && result.count != 2'd0),
      .result          (result),
      .free            (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire
